FILE: rtl/i2ctbe_pkg.sv
// Shared types and constants of the I2C target byte engine.
package i2ctbe_pkg;

    localparam logic [1:0] MODE_START    = 2'd0;
    localparam logic [1:0] MODE_STOP     = 2'd1;
    localparam logic [1:0] MODE_OVERFLOW = 2'd2;
    localparam logic [1:0] MODE_REPLY    = 2'd3;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_REARM = 2'd1;
    localparam logic [1:0] KIND_HOST  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [7:0] FILLER_BYTE = 8'hfe;
    localparam logic [7:0] IDLE_BYTE   = 8'hff;
    localparam logic [3:0] BITS_BYTE   = 4'd8;
    localparam logic [3:0] BITS_ACK    = 4'd1;
    localparam logic [3:0] BITS_NONE   = 4'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [2:0] {
        BP_CHECK_ADDRESS = 3'd0,
        BP_SEND_DATA     = 3'd1,
        BP_REQUEST_ACK   = 3'd2,
        BP_CHECK_ACK     = 3'd3,
        BP_RECEIVE_DATA  = 3'd4,
        BP_STORE_DATA    = 3'd5
    } t_byte_phase;

    typedef enum logic [2:0] {
        TP_BEFORE_START = 3'd0,
        TP_AFTER_START  = 3'd1,
        TP_SELECTED     = 3'd2,
        TP_NOT_SELECTED = 3'd3,
        TP_DATA_DONE    = 3'd4
    } t_txn_phase;

    typedef enum logic {
        F_IDLE = 1'b0,
        F_EXEC = 1'b1
    } t_front_state;

    typedef enum logic {
        B_IDLE = 1'b0,
        B_EMIT = 1'b1
    } t_back_state;

    // One entry of the command queue; run set means deliver run_len stored bytes
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] shift_byte;
        logic [3:0] shift_bits;
        logic       drive_sda;
        logic       release_lines;
        logic       run;
        logic [7:0] run_len;
    } t_cmd;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_store_wr;

endpackage

FILE: rtl/i2ctbe_if.sv
// Request and result channel interfaces of the I2C target byte engine.
interface i2ctbe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       sda_high;
    logic [7:0] bus_byte;
    logic [7:0] reply_byte;

    modport source (output valid, mode, sda_high, bus_byte, reply_byte, input ready);
    modport sink   (input valid, mode, sda_high, bus_byte, reply_byte, output ready);
endinterface

interface i2ctbe_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] shift_byte;
    logic [3:0] shift_bits;
    logic       drive_sda;
    logic       release_lines;
    logic [7:0] host_byte;
    logic [3:0] byte_count;
    logic       last;

    modport source (output valid, kind, shift_byte, shift_bits, drive_sda, release_lines,
                    host_byte, byte_count, last, input ready);
    modport sink   (input valid, kind, shift_byte, shift_bits, drive_sda, release_lines,
                    host_byte, byte_count, last, output ready);
endinterface

FILE: rtl/i2ctbe_front.sv
// Front end: takes requests, runs the bus protocol state and queues commands.
module i2ctbe_front #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    i2ctbe_in_if.sink                        i_req,
    input  logic                             i_cfg_we,
    input  logic [6:0]                       i_cfg_data,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output i2ctbe_pkg::t_cmd                 o_q_cmd,
    output i2ctbe_pkg::t_store_wr            o_store_wr,
    output logic [$clog2(BUFFER_DEPTH)-1:0]  o_store_addr,
    input  logic                             i_run_done,
    output logic                             o_busy
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = $clog2(BUFFER_DEPTH + 1);

    i2ctbe_pkg::t_front_state r_state, n_state;
    i2ctbe_pkg::t_byte_phase  r_bp, n_bp;
    i2ctbe_pkg::t_txn_phase   r_tp, n_tp;

    logic [1:0]    r_mode;
    logic          r_sda;
    logic [7:0]    r_bus;
    logic [7:0]    r_rb;
    logic [7:0]    r_reply_rd;
    logic [6:0]    r_own;
    logic          r_armed, n_armed;
    logic [AW-1:0] r_recv_cnt, n_recv_cnt;
    logic [PW-1:0] r_reply_cnt, n_reply_cnt;
    logic [PW-1:0] r_reply_ptr, n_reply_ptr;
    logic          r_busy, n_busy;
    logic [7:0]    r_reply_mem [BUFFER_DEPTH];

    logic          w_accept;
    logic          w_reply_we;
    i2ctbe_pkg::t_cmd w_cmd;

    // next state of the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2ctbe_pkg::F_IDLE: begin
                if (w_accept) begin
                    n_state = i2ctbe_pkg::F_EXEC;
                end
            end
            i2ctbe_pkg::F_EXEC: begin
                if (!i_q_full) begin
                    n_state = i2ctbe_pkg::F_IDLE;
                end
            end
            default: n_state = i2ctbe_pkg::F_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_req.ready = (r_state == i2ctbe_pkg::F_IDLE) && !r_busy;
        o_q_push    = (r_state == i2ctbe_pkg::F_EXEC) && !i_q_full;
    end

    assign w_accept = i_req.valid && i_req.ready;
    assign o_busy   = r_busy;
    assign o_q_cmd  = w_cmd;

    // protocol step for the registered request
    always_comb begin
        n_bp         = r_bp;
        n_tp         = r_tp;
        n_armed      = r_armed;
        n_recv_cnt   = r_recv_cnt;
        n_reply_cnt  = r_reply_cnt;
        n_reply_ptr  = r_reply_ptr;
        n_busy       = r_busy;
        w_reply_we   = 1'b0;
        o_store_wr   = '{en: 1'b0, data: r_bus};
        o_store_addr = r_recv_cnt;
        w_cmd        = '{kind: i2ctbe_pkg::KIND_NONE, shift_byte: 8'd0,
                         shift_bits: i2ctbe_pkg::BITS_NONE, drive_sda: 1'b0,
                         release_lines: 1'b0, run: 1'b0, run_len: 8'd0};
        case (r_mode)
            i2ctbe_pkg::MODE_START: begin
                if (r_sda) begin
                    n_armed = 1'b0;
                    w_cmd.kind = i2ctbe_pkg::KIND_REARM;
                    w_cmd.shift_bits = i2ctbe_pkg::BITS_BYTE;
                    w_cmd.release_lines = 1'b1;
                end else begin
                    n_bp = i2ctbe_pkg::BP_CHECK_ADDRESS;
                    n_tp = i2ctbe_pkg::TP_AFTER_START;
                    n_armed = 1'b1;
                    w_cmd.kind = i2ctbe_pkg::KIND_CMD;
                    w_cmd.shift_byte = i2ctbe_pkg::IDLE_BYTE;
                    w_cmd.shift_bits = i2ctbe_pkg::BITS_BYTE;
                end
            end
            i2ctbe_pkg::MODE_STOP: begin
                if (r_tp == i2ctbe_pkg::TP_AFTER_START) begin
                    n_armed = 1'b0;
                    w_cmd.kind = i2ctbe_pkg::KIND_REARM;
                    w_cmd.shift_bits = i2ctbe_pkg::BITS_BYTE;
                    w_cmd.release_lines = 1'b1;
                end else if (r_tp == i2ctbe_pkg::TP_DATA_DONE) begin
                    n_reply_cnt = '0;
                    n_reply_ptr = '0;
                    n_recv_cnt = '0;
                    w_cmd.kind = i2ctbe_pkg::KIND_HOST;
                    if (r_recv_cnt != '0) begin
                        // hand the stored bytes to the back end; hold requests until done
                        w_cmd.run = 1'b1;
                        w_cmd.run_len = 8'(r_recv_cnt);
                        n_busy = 1'b1;
                    end
                end
                n_tp = i2ctbe_pkg::TP_BEFORE_START;
            end
            i2ctbe_pkg::MODE_OVERFLOW: begin
                if (r_armed) begin
                    case (r_bp)
                        i2ctbe_pkg::BP_CHECK_ADDRESS: begin
                            if (r_bus[7:1] == r_own) begin
                                n_tp = i2ctbe_pkg::TP_SELECTED;
                                n_bp = r_bus[0] ? i2ctbe_pkg::BP_SEND_DATA
                                                : i2ctbe_pkg::BP_RECEIVE_DATA;
                                w_cmd.kind = i2ctbe_pkg::KIND_CMD;
                                w_cmd.shift_bits = i2ctbe_pkg::BITS_ACK;
                                w_cmd.drive_sda = 1'b1;
                            end else begin
                                n_tp = i2ctbe_pkg::TP_NOT_SELECTED;
                                n_armed = 1'b0;
                                w_cmd.kind = i2ctbe_pkg::KIND_REARM;
                                w_cmd.shift_bits = i2ctbe_pkg::BITS_BYTE;
                            end
                        end
                        i2ctbe_pkg::BP_REQUEST_ACK: begin
                            n_bp = i2ctbe_pkg::BP_CHECK_ACK;
                            w_cmd.kind = i2ctbe_pkg::KIND_CMD;
                            w_cmd.shift_bits = i2ctbe_pkg::BITS_ACK;
                        end
                        i2ctbe_pkg::BP_SEND_DATA, i2ctbe_pkg::BP_CHECK_ACK: begin
                            if (r_bp == i2ctbe_pkg::BP_CHECK_ACK && r_bus != 8'd0) begin
                                // master NACK: end of read
                                n_bp = i2ctbe_pkg::BP_CHECK_ADDRESS;
                                n_armed = 1'b0;
                                w_cmd.kind = i2ctbe_pkg::KIND_REARM;
                                w_cmd.shift_bits = i2ctbe_pkg::BITS_BYTE;
                                w_cmd.release_lines = 1'b1;
                            end else begin
                                n_tp = i2ctbe_pkg::TP_DATA_DONE;
                                n_bp = i2ctbe_pkg::BP_REQUEST_ACK;
                                w_cmd.kind = i2ctbe_pkg::KIND_CMD;
                                w_cmd.shift_byte = i2ctbe_pkg::FILLER_BYTE;
                                w_cmd.shift_bits = i2ctbe_pkg::BITS_BYTE;
                                w_cmd.drive_sda = 1'b1;
                                if (r_reply_ptr < r_reply_cnt) begin
                                    w_cmd.shift_byte = r_reply_rd;
                                    n_reply_ptr = r_reply_ptr + PW'(1);
                                end
                            end
                        end
                        i2ctbe_pkg::BP_RECEIVE_DATA: begin
                            n_tp = i2ctbe_pkg::TP_DATA_DONE;
                            n_bp = i2ctbe_pkg::BP_STORE_DATA;
                            w_cmd.kind = i2ctbe_pkg::KIND_CMD;
                            w_cmd.shift_byte = r_bus;
                            w_cmd.shift_bits = i2ctbe_pkg::BITS_BYTE;
                        end
                        i2ctbe_pkg::BP_STORE_DATA: begin
                            n_bp = i2ctbe_pkg::BP_RECEIVE_DATA;
                            if (r_recv_cnt < AW'(BUFFER_DEPTH - 1)) begin
                                o_store_wr.en = 1'b1;
                                n_recv_cnt = r_recv_cnt + AW'(1);
                            end
                            w_cmd.kind = i2ctbe_pkg::KIND_CMD;
                            w_cmd.shift_bits = i2ctbe_pkg::BITS_ACK;
                            w_cmd.drive_sda = 1'b1;
                        end
                        default: begin
                            n_bp = i2ctbe_pkg::BP_CHECK_ADDRESS;
                        end
                    endcase
                end
            end
            default: begin
                // host reply byte; drop it once the reply store is full
                if (r_reply_cnt < PW'(BUFFER_DEPTH)) begin
                    w_reply_we = 1'b1;
                    n_reply_cnt = r_reply_cnt + PW'(1);
                end
            end
        endcase
        if (i_run_done) begin
            n_busy = 1'b0;
        end
        if (!o_q_push) begin
            o_store_wr.en = 1'b0;
            w_reply_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2ctbe_pkg::F_IDLE;
            r_bp        <= i2ctbe_pkg::BP_CHECK_ADDRESS;
            r_tp        <= i2ctbe_pkg::TP_BEFORE_START;
            r_armed     <= 1'b0;
            r_recv_cnt  <= '0;
            r_reply_cnt <= '0;
            r_reply_ptr <= '0;
            r_busy      <= 1'b0;
            r_own       <= 7'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_own <= i_cfg_data;
            end
            if (o_q_push) begin
                r_bp        <= n_bp;
                r_tp        <= n_tp;
                r_armed     <= n_armed;
                r_recv_cnt  <= n_recv_cnt;
                r_reply_cnt <= n_reply_cnt;
                r_reply_ptr <= n_reply_ptr;
                r_busy      <= n_busy;
            end else if (i_run_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // request capture and reply store read, both at the accepting edge
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= i_req.mode;
            r_sda      <= i_req.sda_high;
            r_bus      <= i_req.bus_byte;
            r_rb       <= i_req.reply_byte;
            r_reply_rd <= r_reply_mem[r_reply_ptr[AW-1:0]];
        end
        if (w_reply_we) begin
            r_reply_mem[r_reply_cnt[AW-1:0]] <= r_rb;
        end
    end

endmodule

FILE: rtl/i2ctbe_queue.sv
// Short command queue between front and back ends.
module i2ctbe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2ctbe_pkg::t_cmd i_cmd,
    input  logic             i_pop,
    output i2ctbe_pkg::t_cmd o_head,
    output logic             o_empty,
    output logic             o_full
);
    i2ctbe_pkg::t_cmd r_mem [i2ctbe_pkg::QUEUE_DEPTH];

    logic [i2ctbe_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [i2ctbe_pkg::QUEUE_AW:0]   r_fill;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == (i2ctbe_pkg::QUEUE_AW + 1)'(i2ctbe_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + i2ctbe_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + i2ctbe_pkg::QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (i2ctbe_pkg::QUEUE_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - (i2ctbe_pkg::QUEUE_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/i2ctbe_back.sv
// Back end: carries out queued commands and delivers received-byte runs.
module i2ctbe_back #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  i2ctbe_pkg::t_cmd                 i_head,
    input  logic                             i_empty,
    output logic                             o_pop,
    input  i2ctbe_pkg::t_store_wr            i_store_wr,
    input  logic [$clog2(BUFFER_DEPTH)-1:0]  i_store_addr,
    output logic                             o_run_done,
    i2ctbe_out_if.source                     o_rsp
);
    localparam int AW = $clog2(BUFFER_DEPTH);

    i2ctbe_pkg::t_back_state r_state, n_state;

    logic [7:0]    r_recv_mem [BUFFER_DEPTH];
    logic [7:0]    r_rd;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_len;
    logic [AW+3:0] w_len_ext;
    logic          w_can_load, w_load_cmd, w_load_run, w_is_last;

    logic       r_ov;
    logic [1:0] r_kind;
    logic [7:0] r_shift_byte;
    logic [3:0] r_shift_bits;
    logic       r_drive;
    logic       r_rel;
    logic [7:0] r_host;
    logic [3:0] r_count;
    logic       r_last;

    assign w_can_load = !r_ov || o_rsp.ready;
    assign w_is_last  = ({1'b0, r_idx} + (AW + 1)'(1)) == {1'b0, r_len};
    assign w_len_ext  = {4'd0, r_len};

    always_comb begin
        n_state = r_state;
        case (r_state)
            i2ctbe_pkg::B_IDLE: begin
                if (!i_empty && i_head.run) begin
                    n_state = i2ctbe_pkg::B_EMIT;
                end
            end
            i2ctbe_pkg::B_EMIT: begin
                if (w_can_load && w_is_last) begin
                    n_state = i2ctbe_pkg::B_IDLE;
                end
            end
            default: n_state = i2ctbe_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = (r_state == i2ctbe_pkg::B_IDLE) && !i_empty && (i_head.run || w_can_load);
        w_load_cmd = (r_state == i2ctbe_pkg::B_IDLE) && !i_empty && !i_head.run && w_can_load;
        w_load_run = (r_state == i2ctbe_pkg::B_EMIT) && w_can_load;
        o_run_done = w_load_run && w_is_last;
        n_idx      = r_idx;
        if (r_state == i2ctbe_pkg::B_IDLE) begin
            n_idx = '0;
        end else if (w_load_run) begin
            n_idx = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2ctbe_pkg::B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_cmd || w_load_run) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_pop && i_head.run) begin
            r_len <= i_head.run_len[AW-1:0];
        end
        if (w_load_cmd) begin
            r_kind       <= i_head.kind;
            r_shift_byte <= i_head.shift_byte;
            r_shift_bits <= i_head.shift_bits;
            r_drive      <= i_head.drive_sda;
            r_rel        <= i_head.release_lines;
            r_host       <= 8'd0;
            r_count      <= 4'd0;
            r_last       <= 1'b1;
        end else if (w_load_run) begin
            r_kind       <= i2ctbe_pkg::KIND_HOST;
            r_shift_byte <= 8'd0;
            r_shift_bits <= i2ctbe_pkg::BITS_NONE;
            r_drive      <= 1'b0;
            r_rel        <= 1'b0;
            r_host       <= r_rd;
            r_count      <= w_len_ext[3:0];
            r_last       <= w_is_last;
        end
    end

    // receive store: one write port from the front, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_recv_mem[i_store_addr] <= i_store_wr.data;
        end
        r_rd <= r_recv_mem[n_idx];
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.kind          = r_kind;
    assign o_rsp.shift_byte    = r_shift_byte;
    assign o_rsp.shift_bits    = r_shift_bits;
    assign o_rsp.drive_sda     = r_drive;
    assign o_rsp.release_lines = r_rel;
    assign o_rsp.host_byte     = r_host;
    assign o_rsp.byte_count    = r_count;
    assign o_rsp.last          = r_last;

endmodule

FILE: rtl/i2c_target_byte_engine.sv
// Top level of the I2C target byte engine: front end, command queue, back end.
// Path: a request is captured, then stepped and pushed into the queue, then loaded
// into the output register; run bytes load in the emit state; stalls can delay both.
// No request is taken while the last one is stepped and pushed, nor during a run.
// A stop after data gives its stored bytes one a cycle while o_rsp.ready is high.
// Reset: synchronous, active low; clears phases, counts and queue; stores stay undefined.
module i2c_target_byte_engine #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2ctbe_in_if.sink     i_req,
    i2ctbe_out_if.source  o_rsp,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_data
);
    localparam int AW = $clog2(BUFFER_DEPTH);

    // command queue ports, front and back
    logic                  w_q_push;
    logic                  w_q_full;
    logic                  w_q_empty;
    logic                  w_q_pop;
    i2ctbe_pkg::t_cmd      w_q_in;
    i2ctbe_pkg::t_cmd      w_q_head;

    // receive store write, front to back, and end of a delivered run
    i2ctbe_pkg::t_store_wr w_store_wr;
    logic [AW-1:0]         w_store_addr;
    logic                  w_run_done;
    logic                  w_front_busy;

    // Classify each request and advance the bus protocol; one queue entry per request.
    i2ctbe_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_cmd     (w_q_in),
        .o_store_wr  (w_store_wr),
        .o_store_addr(w_store_addr),
        .i_run_done  (w_run_done),
        .o_busy      (w_front_busy)
    );

    // Decouple the two halves so a stalled result side does not stop request capture until the queue fills.
    i2ctbe_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_cmd  (w_q_in),
        .i_pop  (w_q_pop),
        .o_head (w_q_head),
        .o_empty(w_q_empty),
        .o_full (w_q_full)
    );

    // Drive results out; expand a run command into one result per stored byte.
    i2ctbe_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_q_head),
        .i_empty     (w_q_empty),
        .o_pop       (w_q_pop),
        .i_store_wr  (w_store_wr),
        .i_store_addr(w_store_addr),
        .o_run_done  (w_run_done),
        .o_rsp       (o_rsp)
    );

    // no request is taken while a run is still being delivered
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_busy |-> !i_req.ready)
        else $error("request accepted during a receive run");

    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("command queue overflow");

    // the receive store is never written while a run reads it
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_busy |-> !w_store_wr.en)
        else $error("receive store written during a run");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid after reset");

endmodule
